FILE: src/vnorm_pkg.sv
`timescale 1ns / 1ps

package vnorm_pkg;

    localparam int MAX_LENGTH    = 64;
    localparam int ELEMENT_WIDTH = 16;

    localparam int EL_W      = ELEMENT_WIDTH;
    localparam int SQ_W      = 2 * EL_W;
    localparam int SUM_W     = 37;
    localparam int NORM_W    = 19;
    localparam int UNIT_W    = 16;
    localparam int IDX_W     = $clog2(MAX_LENGTH);
    localparam int CNT_W     = $clog2(MAX_LENGTH + 1);
    localparam int RAD_W     = 2 * NORM_W;
    localparam int REM_W     = NORM_W + 3;
    localparam int DREM_W    = NORM_W + 1;
    localparam int STEP_W    = $clog2(NORM_W + 1);

    localparam logic [UNIT_W-1:0] UNIT_MAX = UNIT_W'((1 << (UNIT_W - 1)) - 1);

    typedef struct packed {
        logic signed [EL_W-1:0] element;
        logic                   is_last;
    } vnorm_in_t;

    typedef struct packed {
        logic signed [UNIT_W-1:0] unit_element;
        logic [NORM_W-1:0]        norm;
        logic                     zero_norm;
        logic                     end_of_run;
    } vnorm_out_t;

    typedef struct packed {
        logic start;
        logic done;
    } vnorm_unit_ctl_t;

endpackage

FILE: src/vnorm_sqrt.sv
`timescale 1ns / 1ps

module vnorm_sqrt (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    input  logic [vnorm_pkg::SUM_W-1:0]      radicand,
    output logic                             done,
    output logic [vnorm_pkg::NORM_W-1:0]     root
);

    logic [vnorm_pkg::RAD_W-1:0]  rad_reg;
    logic [vnorm_pkg::RAD_W-1:0]  rad_next;
    logic [vnorm_pkg::REM_W-1:0]  rem_reg;
    logic [vnorm_pkg::REM_W-1:0]  rem_next;
    logic [vnorm_pkg::NORM_W-1:0] root_reg;
    logic [vnorm_pkg::NORM_W-1:0] root_next;
    logic [vnorm_pkg::STEP_W-1:0] step_reg;
    logic [vnorm_pkg::STEP_W-1:0] step_next;
    logic                         busy_reg;
    logic                         busy_next;
    logic                         done_reg;
    logic                         done_next;
    logic [vnorm_pkg::REM_W-1:0]  rem_sh;
    logic [vnorm_pkg::REM_W-1:0]  trial;
    logic                         fits;

    // One result bit per cycle: two radicand bits are brought down each step.
    assign rem_sh = {rem_reg[vnorm_pkg::REM_W-3:0],
                     rad_reg[vnorm_pkg::RAD_W-1:vnorm_pkg::RAD_W-2]};
    assign trial  = {1'b0, root_reg, 2'b01};
    assign fits   = (rem_sh >= trial);

    always_comb
    begin
        rad_next  = rad_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rad_next  = vnorm_pkg::RAD_W'(radicand);
            rem_next  = '0;
            root_next = '0;
            step_next = vnorm_pkg::STEP_W'(vnorm_pkg::NORM_W - 1);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rad_next  = {rad_reg[vnorm_pkg::RAD_W-3:0], 2'b00};
            rem_next  = fits ? (rem_sh - trial) : rem_sh;
            root_next = {root_reg[vnorm_pkg::NORM_W-2:0], fits};
            step_next = step_reg - vnorm_pkg::STEP_W'(1);
            if (step_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rad_reg  <= rad_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

FILE: src/vnorm_div.sv
`timescale 1ns / 1ps

module vnorm_div (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    input  logic [vnorm_pkg::EL_W-1:0]       magnitude,
    input  logic [vnorm_pkg::NORM_W-1:0]     divisor,
    output logic                             done,
    output logic [vnorm_pkg::UNIT_W-1:0]     quotient
);

    logic [vnorm_pkg::DREM_W-1:0] rem_reg;
    logic [vnorm_pkg::DREM_W-1:0] rem_next;
    logic [vnorm_pkg::UNIT_W-1:0] quo_reg;
    logic [vnorm_pkg::UNIT_W-1:0] quo_next;
    logic [vnorm_pkg::STEP_W-1:0] step_reg;
    logic [vnorm_pkg::STEP_W-1:0] step_next;
    logic                         busy_reg;
    logic                         busy_next;
    logic                         done_reg;
    logic                         done_next;
    logic [vnorm_pkg::DREM_W:0]   diff;
    logic                         fits;
    logic [vnorm_pkg::DREM_W-1:0] kept;

    // The magnitude never exceeds the norm, so the partial remainder starts as the
    // magnitude itself and only the top quotient bit carries the integer part, which is at most one.
    assign diff = {1'b0, rem_reg} - {2'b00, divisor};
    assign fits = ~diff[vnorm_pkg::DREM_W];
    assign kept = fits ? diff[vnorm_pkg::DREM_W-1:0] : rem_reg;

    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = vnorm_pkg::DREM_W'(magnitude);
            quo_next  = '0;
            step_next = vnorm_pkg::STEP_W'(vnorm_pkg::UNIT_W - 1);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next  = {kept[vnorm_pkg::DREM_W-2:0], 1'b0};
            quo_next  = {quo_reg[vnorm_pkg::UNIT_W-2:0], fits};
            step_next = step_reg - vnorm_pkg::STEP_W'(1);
            if (step_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

FILE: src/vector_normalize.sv
`timescale 1ns / 1ps
// Loading takes one cycle per word; words without the last flag give no result.
// After the closing word the square root is computed in the root unit.
// Each result passes through the store read, the divider start, 16 divider steps and
// the output register, or skips the divider under a zero norm, and is then held until
// result_ready takes it in the output state.
// Reset clears the control state, the running sum and the element count; the store is kept.
module vector_normalize (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   item_valid,
    output logic                   item_ready,
    input  vnorm_pkg::vnorm_in_t   item,
    output logic                   result_valid,
    input  logic                   result_ready,
    output vnorm_pkg::vnorm_out_t  result
);

    localparam logic [2:0] S_LOAD   = 3'd0;
    localparam logic [2:0] S_RSTART = 3'd1;
    localparam logic [2:0] S_ROOT   = 3'd2;
    localparam logic [2:0] S_FETCH  = 3'd3;
    localparam logic [2:0] S_START  = 3'd4;
    localparam logic [2:0] S_DIV    = 3'd5;
    localparam logic [2:0] S_OUT    = 3'd6;

    logic [2:0]                       state_reg;
    logic [2:0]                       state_next;
    logic [vnorm_pkg::SUM_W-1:0]      sum_reg;
    logic [vnorm_pkg::SUM_W-1:0]      sum_next;
    logic [vnorm_pkg::CNT_W-1:0]      count_reg;
    logic [vnorm_pkg::CNT_W-1:0]      count_next;
    logic [vnorm_pkg::IDX_W-1:0]      k_reg;
    logic [vnorm_pkg::IDX_W-1:0]      k_next;
    logic [vnorm_pkg::NORM_W-1:0]     norm_reg;
    logic [vnorm_pkg::NORM_W-1:0]     norm_next;
    logic                             out_valid_reg;
    logic                             out_valid_next;
    vnorm_pkg::vnorm_out_t            out_reg;
    vnorm_pkg::vnorm_out_t            out_next;
    logic signed [vnorm_pkg::EL_W-1:0] rd_data_reg;

    logic signed [vnorm_pkg::EL_W-1:0] store [vnorm_pkg::MAX_LENGTH];

    logic                             accept;
    logic                             room;
    logic [vnorm_pkg::EL_W-1:0]       in_mag;
    logic [vnorm_pkg::SQ_W-1:0]       in_square;
    logic [vnorm_pkg::EL_W-1:0]       rd_mag;
    logic                             last_k;
    vnorm_pkg::vnorm_unit_ctl_t       root_ctl;
    vnorm_pkg::vnorm_unit_ctl_t       div_ctl;
    logic [vnorm_pkg::NORM_W-1:0]     root_val;
    logic [vnorm_pkg::UNIT_W-1:0]     quo_val;
    logic [vnorm_pkg::UNIT_W-1:0]     unit_val;

    assign item_ready = (state_reg == S_LOAD);
    assign accept     = item_valid && item_ready;
    assign room       = (count_reg < vnorm_pkg::CNT_W'(vnorm_pkg::MAX_LENGTH));

    assign in_mag    = item.element[vnorm_pkg::EL_W-1] ? vnorm_pkg::EL_W'(-item.element)
                                                        : vnorm_pkg::EL_W'(item.element);
    assign in_square = vnorm_pkg::SQ_W'(in_mag) * vnorm_pkg::SQ_W'(in_mag);

    assign rd_mag = rd_data_reg[vnorm_pkg::EL_W-1] ? vnorm_pkg::EL_W'(-rd_data_reg)
                                                    : vnorm_pkg::EL_W'(rd_data_reg);
    assign last_k = ((vnorm_pkg::CNT_W'(k_reg) + vnorm_pkg::CNT_W'(1)) == count_reg);

    // The quotient never exceeds one, so only a positive one needs saturating.
    assign unit_val = rd_data_reg[vnorm_pkg::EL_W-1] ? vnorm_pkg::UNIT_W'(~quo_val + 1'b1)
                    : (quo_val[vnorm_pkg::UNIT_W-1] ? vnorm_pkg::UNIT_MAX : quo_val);

    assign root_ctl.start = (state_reg == S_RSTART);
    assign div_ctl.start  = (state_reg == S_START) && (norm_reg != '0);

    vnorm_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (root_ctl.start),
        .radicand (sum_reg),
        .done     (root_ctl.done),
        .root     (root_val)
    );

    vnorm_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_ctl.start),
        .magnitude (rd_mag),
        .divisor   (norm_reg),
        .done      (div_ctl.done),
        .quotient  (quo_val)
    );

    always_comb
    begin
        state_next     = state_reg;
        sum_next       = sum_reg;
        count_next     = count_reg;
        k_next         = k_reg;
        norm_next      = norm_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        case (state_reg)
            S_LOAD:
            begin
                if (accept)
                begin
                    if (room)
                    begin
                        count_next = count_reg + vnorm_pkg::CNT_W'(1);
                        sum_next   = sum_reg + vnorm_pkg::SUM_W'(in_square);
                    end
                    if (item.is_last)
                    begin
                        state_next = S_RSTART;
                    end
                end
            end
            S_RSTART:
            begin
                state_next = S_ROOT;
            end
            S_ROOT:
            begin
                if (root_ctl.done)
                begin
                    norm_next  = root_val;
                    k_next     = '0;
                    state_next = S_FETCH;
                end
            end
            S_FETCH:
            begin
                state_next = S_START;
            end
            S_START:
            begin
                if (norm_reg == '0)
                begin
                    out_next.unit_element = '0;
                    out_next.norm         = '0;
                    out_next.zero_norm    = 1'b1;
                    out_next.end_of_run   = last_k;
                    out_valid_next        = 1'b1;
                    state_next            = S_OUT;
                end
                else
                begin
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                if (div_ctl.done)
                begin
                    out_next.unit_element = unit_val;
                    out_next.norm         = norm_reg;
                    out_next.zero_norm    = 1'b0;
                    out_next.end_of_run   = last_k;
                    out_valid_next        = 1'b1;
                    state_next            = S_OUT;
                end
            end
            S_OUT:
            begin
                if (result_ready)
                begin
                    out_valid_next = 1'b0;
                    if (last_k)
                    begin
                        sum_next   = '0;
                        count_next = '0;
                        state_next = S_LOAD;
                    end
                    else
                    begin
                        k_next     = k_reg + vnorm_pkg::IDX_W'(1);
                        state_next = S_FETCH;
                    end
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_LOAD;
            sum_reg       <= '0;
            count_reg     <= '0;
            k_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sum_reg       <= sum_next;
            count_reg     <= count_next;
            k_reg         <= k_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        norm_reg <= norm_next;
        out_reg  <= out_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept && room)
        begin
            store[count_reg[vnorm_pkg::IDX_W-1:0]] <= item.element;
        end
        if (state_reg == S_FETCH)
        begin
            rd_data_reg <= store[k_reg];
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

endmodule

FILE: src/vnorm_checker.sv
`timescale 1ns / 1ps

module vnorm_checker (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   item_valid,
    input  logic                   item_ready,
    input  vnorm_pkg::vnorm_in_t   item,
    input  logic                   result_valid,
    input  logic                   result_ready,
    input  vnorm_pkg::vnorm_out_t  result
);

    // Words are loaded and results are emitted in separate phases.
    assert property (@(posedge clk) disable iff (!rst_n)
        !(item_ready && result_valid))
        else $error("input ready while a result is offered");

    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result))
        else $error("stalled result changed");

    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result.zero_norm == (result.norm == '0)))
        else $error("zero norm flag disagrees with the norm");

    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.zero_norm |-> (result.unit_element == '0))
        else $error("non-zero result under a zero norm");

    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_ready |=> (item_ready == $past(result.end_of_run)))
        else $error("loading did not resume exactly after the final result");

endmodule

bind vector_normalize vnorm_checker u_vnorm_checker (.*);
